/* src/hccfb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package hccfb_pkg;

  localparam int unsigned FRAME_LEN          = 10;
  localparam int unsigned IDX_W              = $clog2(FRAME_LEN);
  localparam logic [7:0]  PROCESS_CODE_RESET = 8'h6D;
  localparam logic [15:0] CRC_POLY           = 16'h1021;
  localparam logic [15:0] CRC_INIT           = 16'h0000;
  localparam logic [7:0]  CHAR_CR            = 8'h0D;
  localparam logic [7:0]  CHAR_LF            = 8'h0A;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } nib_t;

  // ASCII hex digit to nibble; ok is low for anything else
  function automatic nib_t nibble_of(input logic [7:0] c);
    nib_t n;
    n.ok  = 1'b0;
    n.val = 4'h0;
    if (c >= 8'h30 && c <= 8'h39) begin
      n.ok  = 1'b1;
      n.val = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      n.ok  = 1'b1;
      n.val = c[3:0] + 4'd9;
    end
    return n;
  endfunction

  // one byte through CRC-16/XMODEM, msb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* src/hex_command_crc_frame_builder_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Hex command frame builder. Characters arrive one per transfer on the in_
// stream; two hex digits followed by CR or LF produce a ten-byte frame on
// the out_ stream: process code, 00, 00, 00, function byte, 00, CRC-16/XMODEM
// of bytes 0-5 (high byte first), then the CRC of bytes 0-7; tlast marks the
// tenth byte. Any other character, or a line end with fewer than two digits,
// discards the digits without output. Characters are taken one per cycle; a
// line end that starts a frame waits in the input register until the frame
// before it has gone, and the CRC is updated one byte per output transfer.
// cfg_wr_en loads the process code (reset 0x6D); write it only while the
// block is idle.
module hex_command_crc_frame_builder_core
  import hccfb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] rx_char
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] frame_byte
  output logic            out_tlast   // frame_last
);

  localparam logic [IDX_W-1:0] IDX_FUNC    = IDX_W'(4);
  localparam logic [IDX_W-1:0] IDX_CRC1_HI = IDX_W'(6);
  localparam logic [IDX_W-1:0] IDX_CRC1_LO = IDX_W'(7);
  localparam logic [IDX_W-1:0] IDX_CRC2_HI = IDX_W'(8);
  localparam logic [IDX_W-1:0] IDX_LAST    = IDX_W'(FRAME_LEN - 1);

  logic [7:0]       pcode_r;
  logic             in_full_r;
  logic [7:0]       in_char_r;
  logic [1:0]       cnt_r, cnt_nxt;
  logic [3:0]       store_r [2];
  logic [7:0]       func_r;
  logic             ovalid_r, ovalid_nxt;
  logic             olast_r, olast_nxt;
  logic [7:0]       obyte_r, obyte_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [15:0]      hold_r, hold_nxt;

  logic out_xfer, can_start, is_eol, is_frame, consume, start;
  nib_t nib;

  assign out_xfer  = ovalid_r && out_tready;
  assign can_start = !ovalid_r || (out_xfer && olast_r);
  assign is_eol    = (in_char_r == CHAR_CR) || (in_char_r == CHAR_LF);
  assign is_frame  = is_eol && (cnt_r == 2'd2);
  assign consume   = in_full_r && (!is_frame || can_start);
  assign start     = consume && is_frame;
  assign in_tready = !in_full_r || consume;
  assign nib       = nibble_of(in_char_r);

  assign out_tvalid = ovalid_r;
  assign out_tdata  = obyte_r;
  assign out_tlast  = olast_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (consume) begin
      if (is_eol || !nib.ok) begin
        cnt_nxt = 2'd0;
      end else if (cnt_r != 2'd2) begin
        cnt_nxt = cnt_r + 2'd1;
      end
    end
  end

  always_comb begin
    ovalid_nxt = ovalid_r;
    olast_nxt  = olast_r;
    obyte_nxt  = obyte_r;
    idx_nxt    = idx_r;
    crc_nxt    = crc_r;
    hold_nxt   = hold_r;
    if (start) begin
      ovalid_nxt = 1'b1;
      olast_nxt  = 1'b0;
      obyte_nxt  = pcode_r;
      idx_nxt    = '0;
      crc_nxt    = CRC_INIT;
    end else if (out_xfer) begin
      if (olast_r) begin
        ovalid_nxt = 1'b0;
      end else begin
        idx_nxt   = idx_r + IDX_W'(1);
        crc_nxt   = crc_byte(crc_r, obyte_r);
        olast_nxt = (idx_nxt == IDX_LAST);
        unique case (idx_nxt)
          IDX_FUNC: obyte_nxt = func_r;
          IDX_CRC1_HI, IDX_CRC2_HI: begin
            // crc over everything sent so far; low byte follows next transfer
            obyte_nxt = crc_nxt[15:8];
            hold_nxt  = crc_nxt;
          end
          IDX_CRC1_LO, IDX_LAST: obyte_nxt = hold_r[7:0];
          default: obyte_nxt = 8'h00;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcode_r   <= PROCESS_CODE_RESET;
      in_full_r <= 1'b0;
      cnt_r     <= 2'd0;
      ovalid_r  <= 1'b0;
      olast_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        pcode_r <= cfg_wr_data;
      end
      if (in_tready) begin
        in_full_r <= in_tvalid;
      end
      cnt_r    <= cnt_nxt;
      ovalid_r <= ovalid_nxt;
      olast_r  <= olast_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_char_r <= in_tdata;
    end
    if (consume && !is_eol && nib.ok && cnt_r != 2'd2) begin
      store_r[cnt_r[0]] <= nib.val;
    end
    if (start) begin
      func_r <= {store_r[0], store_r[1]};
    end
    obyte_r <= obyte_nxt;
    idx_r   <= idx_nxt;
    crc_r   <= crc_nxt;
    hold_r  <= hold_nxt;
  end

endmodule

`default_nettype wire

/* src/hccfb_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module hccfb_checker
  import hccfb_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tlast
);

  logic [IDX_W-1:0] seen_r;

  // bytes transferred since the last frame end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else if (out_tvalid && out_tready) begin
      seen_r <= out_tlast ? '0 : seen_r + IDX_W'(1);
    end
  end

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid straight after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output changed");

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (seen_r == IDX_W'(FRAME_LEN - 1))))
    else $error("tlast not on the tenth byte");

  a_last_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata == 8'h00)
    else $error("final crc byte not zero");

endmodule

bind hex_command_crc_frame_builder_core hccfb_checker u_hccfb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
